### src/oadf_pkg.sv
// Shared constants for the obstacle-avoidance drive controller
`timescale 1ns / 1ps
`default_nettype none
package oadf_pkg;

    localparam int DEF_SAMPLE_BITS  = 12;
    localparam int DEF_SENSOR_COUNT = 5;
    localparam int SENSOR_MAX       = 5;

    localparam int DIST_W      = 23;
    localparam int DIST_MAX    = 4194303;
    localparam int DIST_OFFSET = 1280;
    localparam int TICK_W      = 17;

    localparam int M_TDATA_W = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // drive states
    localparam logic [3:0] ST_WAIT     = 4'd0;
    localparam logic [3:0] ST_WAIT_RUN = 4'd1;
    localparam logic [3:0] ST_FWD      = 4'd2;
    localparam logic [3:0] ST_FWD_RUN  = 4'd3;
    localparam logic [3:0] ST_TL       = 4'd4;
    localparam logic [3:0] ST_TL_RUN   = 4'd5;
    localparam logic [3:0] ST_TR       = 4'd6;
    localparam logic [3:0] ST_TR_RUN   = 4'd7;
    localparam logic [3:0] ST_SPL      = 4'd8;
    localparam logic [3:0] ST_SPL_RUN  = 4'd9;
    localparam logic [3:0] ST_SPR      = 4'd10;
    localparam logic [3:0] ST_SPR_RUN  = 4'd11;
    localparam logic [3:0] ST_REV      = 4'd12;
    localparam logic [3:0] ST_REV_RUN  = 4'd13;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NEAR         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_CLEAR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_CLEAR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_DELAY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CRUISE       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPIN         = 3'd5;

    // register reset values
    localparam logic [7:0]  RST_NEAR         = 8'd30;
    localparam logic [7:0]  RST_CENTER_CLEAR = 8'd20;
    localparam logic [7:0]  RST_OUTER_CLEAR  = 8'd40;
    localparam logic [15:0] RST_START_DELAY  = 16'd1000;
    localparam logic [6:0]  RST_CRUISE       = 7'd30;
    localparam logic [6:0]  RST_SPIN         = 7'd15;

endpackage
`default_nettype wire

### src/obstacle_avoid_drive_fsm.sv
// Obstacle-avoidance drive controller with a bit-serial range conversion
//
// Input beats: s_tuser is the action flag (0 sample set, 1 control tick),
// s_tdata carries five ADC codes. A sample set converts each code to a Q8
// centimetre distance through a restoring divider that yields one quotient
// bit per cycle, shared by the sensors in turn, and updates the LEDs. A tick
// advances the start-delay counter and steps the drive state machine.
// Every input beat gives exactly one output beat with the state, both wheel
// setpoints and the LEDs after that item.
// Flow: a tick goes straight to the final step, which loads the output
// register; a sample set first runs the divider for each sensor in turn,
// NW quotient bits per sensor, NW being the bit length of the divider
// numerator (22 at 12-bit samples), then reaches the final step. One item
// is in work at a time; s_tready is high whenever the block is idle, even
// while an output beat still waits.
// When m_tready is low the finished result stays in the output register and
// the next item waits in its final step until that beat has been taken.
// Reset (aresetn low, synchronous) restores the register defaults, clears
// distances, counter and speeds, sets all LEDs and enters the wait state.
`timescale 1ns / 1ps
`default_nettype none
module obstacle_avoid_drive_fsm
    import oadf_pkg::*;
#(
    parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
    parameter int SENSOR_COUNT = DEF_SENSOR_COUNT
) (
    input  wire logic                                        aclk,
    input  wire logic                                        aresetn,
    input  wire logic                                        s_tvalid,
    output logic                                             s_tready,
    // sample_right, sample_center, sample_left, sample_left_outer,
    // sample_right_outer, zero pad
    input  wire logic [((SENSOR_MAX*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    // action
    input  wire logic                                        s_tuser,
    output logic                                             m_tvalid,
    input  wire logic                                        m_tready,
    // drive_state, right_speed, left_speed, led_amber, led_blue,
    // led_white, zero pad
    output logic [M_TDATA_W-1:0]                             m_tdata,
    input  wire logic                                        cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]                        cfg_index,
    input  wire logic [CFG_DATA_W-1:0]                       cfg_data
);

    localparam logic [63:0] RECIP_NUM =
        ((64'd870400 << SAMPLE_BITS) + 64'd528) / 64'd1056;
    localparam int NW = $clog2(RECIP_NUM + 64'd1);
    localparam int CW = $clog2(NW + 1);
    localparam int EW = ((NW > DIST_W) ? NW : DIST_W) + 1;
    localparam int SW = SENSOR_MAX * SAMPLE_BITS;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_CONV = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    // configuration
    logic [7:0]  near_reg, cclear_reg, oclear_reg;
    logic [15:0] delay_reg;
    logic [6:0]  cruise_reg, spin_reg;

    // block state
    logic [1:0]        phase_reg, phase_next;
    logic [DIST_W-1:0] dist_reg [SENSOR_MAX];
    logic [DIST_W-1:0] dist_next [SENSOR_MAX];
    logic [3:0]        mode_reg, mode_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [7:0]        spr_reg, spr_next, spl_reg, spl_next;
    logic [2:0]        led_reg, led_next;

    // serial divider
    logic [SW-1:0]          smp_reg, smp_next;
    logic [2:0]             idx_reg, idx_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [SAMPLE_BITS-1:0] rem_reg, rem_next;
    logic [NW-1:0]          dvd_reg, dvd_next, quo_reg, quo_next;

    // output register
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic [SAMPLE_BITS-1:0] raw;
    logic [SAMPLE_BITS:0]   trial, trial_diff;
    logic                   trial_ge;
    logic [EW-1:0]          quo_ext, quo_off;
    logic                   dist_sat;
    logic [DIST_W-1:0]      dist_val;
    logic                   dist_near;

    logic signed [DIST_W:0] nr_q8, cc_q8;
    logic signed [DIST_W:0] d_r, d_c, d_l, d_lo, d_ro;
    logic [3:0]             auto_state;
    logic [TICK_W-1:0]      tick_inc;
    logic [7:0]             cs8, ss8;

    assign s_tready = (phase_reg == PH_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    // divider step
    assign raw        = smp_reg[SAMPLE_BITS-1:0];
    assign trial      = {rem_reg, dvd_reg[NW-1]};
    assign trial_ge   = trial >= {1'b0, raw};
    assign trial_diff = trial - {1'b0, raw};

    // distance from the finished quotient
    assign quo_ext  = EW'(quo_reg);
    assign quo_off  = quo_ext - EW'(DIST_OFFSET);
    assign dist_sat = (raw == '0) || (quo_ext > EW'(DIST_MAX + DIST_OFFSET));
    assign dist_val = dist_sat ? DIST_W'(DIST_MAX) : quo_off[DIST_W-1:0];

    assign nr_q8     = $signed({8'd0, near_reg, 8'd0});
    assign cc_q8     = $signed({8'd0, cclear_reg, 8'd0});
    assign dist_near = $signed({dist_val[DIST_W-1], dist_val}) < nr_q8;

    assign d_r  = $signed({dist_reg[0][DIST_W-1], dist_reg[0]});
    assign d_c  = $signed({dist_reg[1][DIST_W-1], dist_reg[1]});
    assign d_l  = $signed({dist_reg[2][DIST_W-1], dist_reg[2]});
    assign d_lo = $signed({dist_reg[3][DIST_W-1], dist_reg[3]});
    assign d_ro = $signed({dist_reg[4][DIST_W-1], dist_reg[4]});

    always_comb begin
        if (d_c < nr_q8 || (d_r < nr_q8 && d_l < nr_q8)) begin
            auto_state = ST_SPL;
        end else if (d_r < nr_q8 && d_c > cc_q8 && d_l > nr_q8) begin
            auto_state = ST_TL;
        end else if (d_ro < nr_q8 && d_r < nr_q8 && d_r > cc_q8) begin
            auto_state = ST_TL;
        end else if (d_r > nr_q8 && d_c > cc_q8 && d_l < nr_q8) begin
            auto_state = ST_TR;
        end else if (d_lo < nr_q8 && d_l < nr_q8 && d_l > cc_q8) begin
            auto_state = ST_TR;
        end else begin
            auto_state = ST_FWD;
        end
    end

    assign tick_inc = (tick_reg == {TICK_W{1'b1}}) ? tick_reg : tick_reg + 1'b1;
    assign cs8      = {1'b0, cruise_reg};
    assign ss8      = {1'b0, spin_reg};

    always_comb begin
        phase_next    = phase_reg;
        dist_next     = dist_reg;
        mode_next     = mode_reg;
        tick_next     = tick_reg;
        spr_next      = spr_reg;
        spl_next      = spl_reg;
        led_next      = led_reg;
        smp_next      = smp_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        rem_next      = rem_reg;
        dvd_next      = dvd_reg;
        quo_next      = quo_reg;
        m_tvalid_next = m_tvalid_reg;
        m_data_next   = m_data_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (phase_reg)
            PH_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser) begin
                        tick_next  = tick_inc;
                        phase_next = PH_DONE;
                        case (mode_reg)
                            ST_WAIT: begin
                                // counter cleared, so the delay test counts from zero
                                tick_next = '0;
                                spr_next  = '0;
                                spl_next  = '0;
                                mode_next = ST_WAIT_RUN;
                            end
                            ST_WAIT_RUN: begin
                                if (tick_inc > TICK_W'(delay_reg)) begin
                                    mode_next = ST_FWD;
                                end
                            end
                            ST_FWD: begin
                                spr_next  = cs8;
                                spl_next  = cs8;
                                mode_next = ST_FWD_RUN;
                            end
                            ST_TL: begin
                                spr_next  = cs8;
                                spl_next  = '0;
                                mode_next = ST_TL_RUN;
                            end
                            ST_TR: begin
                                spr_next  = '0;
                                spl_next  = cs8;
                                mode_next = ST_TR_RUN;
                            end
                            ST_SPL: begin
                                spr_next  = ss8;
                                spl_next  = -ss8;
                                mode_next = ST_SPL_RUN;
                            end
                            ST_SPR: begin
                                spr_next  = -ss8;
                                spl_next  = ss8;
                                mode_next = ST_SPR_RUN;
                            end
                            ST_REV: begin
                                spr_next  = -ss8;
                                spl_next  = -ss8;
                                mode_next = ST_REV_RUN;
                            end
                            ST_FWD_RUN, ST_TL_RUN, ST_TR_RUN, ST_SPL_RUN, ST_SPR_RUN: begin
                                if ((auto_state + 4'd1) != mode_reg) begin
                                    mode_next = auto_state;
                                end
                            end
                            default: begin
                                mode_next = ST_WAIT;
                            end
                        endcase
                    end else begin
                        smp_next   = s_tdata[SW-1:0];
                        idx_next   = '0;
                        cnt_next   = '0;
                        rem_next   = '0;
                        dvd_next   = RECIP_NUM[NW-1:0];
                        quo_next   = '0;
                        phase_next = PH_CONV;
                    end
                end
            end
            PH_CONV: begin
                if (cnt_reg == CW'(NW)) begin
                    dist_next[idx_reg] = dist_val;
                    case (idx_reg)
                        3'd0:    led_next[0] = dist_near;
                        3'd1:    led_next[1] = dist_near;
                        default: led_next[2] = dist_near;
                    endcase
                    smp_next = smp_reg >> SAMPLE_BITS;
                    idx_next = idx_reg + 3'd1;
                    cnt_next = '0;
                    rem_next = '0;
                    dvd_next = RECIP_NUM[NW-1:0];
                    quo_next = '0;
                    if (idx_reg == 3'(SENSOR_COUNT - 1)) begin
                        phase_next = PH_DONE;
                    end
                end else begin
                    rem_next = trial_ge ? trial_diff[SAMPLE_BITS-1:0]
                                        : trial[SAMPLE_BITS-1:0];
                    quo_next = {quo_reg[NW-2:0], trial_ge};
                    dvd_next = {dvd_reg[NW-2:0], 1'b0};
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            PH_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = {1'b0, led_reg[2], led_reg[1], led_reg[0],
                                     spl_reg, spr_reg, mode_reg};
                    phase_next    = PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_reg   <= RST_NEAR;
            cclear_reg <= RST_CENTER_CLEAR;
            oclear_reg <= RST_OUTER_CLEAR;
            delay_reg  <= RST_START_DELAY;
            cruise_reg <= RST_CRUISE;
            spin_reg   <= RST_SPIN;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_NEAR:         near_reg   <= cfg_data[7:0];
                REG_CENTER_CLEAR: cclear_reg <= cfg_data[7:0];
                REG_OUTER_CLEAR:  oclear_reg <= cfg_data[7:0];
                REG_START_DELAY:  delay_reg  <= cfg_data;
                REG_CRUISE:       cruise_reg <= cfg_data[6:0];
                REG_SPIN:         spin_reg   <= cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            for (int i = 0; i < SENSOR_MAX; i++) begin
                dist_reg[i] <= '0;
            end
            mode_reg     <= ST_WAIT;
            tick_reg     <= '0;
            spr_reg      <= '0;
            spl_reg      <= '0;
            led_reg      <= 3'b111;
            m_tvalid_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            dist_reg     <= dist_next;
            mode_reg     <= mode_next;
            tick_reg     <= tick_next;
            spr_reg      <= spr_next;
            spl_reg      <= spl_next;
            led_reg      <= led_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        smp_reg    <= smp_next;
        idx_reg    <= idx_next;
        cnt_reg    <= cnt_next;
        rem_reg    <= rem_next;
        dvd_reg    <= dvd_next;
        quo_reg    <= quo_next;
        m_data_reg <= m_data_next;
    end

    // outer-clear threshold has no effect on the drive decision
    logic unused_oclear;
    assign unused_oclear = ^oclear_reg;

endmodule
`default_nettype wire
